@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/xerd_pkg.sv @@
`timescale 1ns / 1ps

package xerd_pkg;

	// Default depth of the result group queue
	localparam int GROUP_DEPTH_DEFAULT = 4;

	// Code point limits for UTF-8 length selection
	localparam logic [20:0] UTF8_LIM1  = 21'h000080;
	localparam logic [20:0] UTF8_LIM2  = 21'h000800;
	localparam logic [20:0] UTF8_LIM3  = 21'h010000;
	localparam logic [20:0] CODE_LIMIT = 21'h110000;

	// Entity matcher states, one-hot
	typedef enum logic [21:0] {
		ST_IDLE      = 22'h000001,
		ST_AMP       = 22'h000002,
		ST_A         = 22'h000004,
		ST_AM        = 22'h000008,
		ST_AMP_END   = 22'h000010,
		ST_AP        = 22'h000020,
		ST_APO       = 22'h000040,
		ST_APOS_END  = 22'h000080,
		ST_Q         = 22'h000100,
		ST_QU        = 22'h000200,
		ST_QUO       = 22'h000400,
		ST_QUOT_END  = 22'h000800,
		ST_G         = 22'h001000,
		ST_GT_END    = 22'h002000,
		ST_L         = 22'h004000,
		ST_LT_END    = 22'h008000,
		ST_N         = 22'h010000,
		ST_NB        = 22'h020000,
		ST_NBS       = 22'h040000,
		ST_NBSP_END  = 22'h080000,
		ST_HASH      = 22'h100000,
		ST_NUM       = 22'h200000
	} xerd_state_t;

	// Results caused by one input byte: up to four data bytes, or one
	// error result, or one empty end-of-value result
	typedef struct packed {
		logic [3:0][7:0] bytes;   // bytes[0] goes out first
		logic [1:0]      cnt_m1;  // number of results minus one
		logic            data;    // results carry bytes
		logic            err;     // single error result
		logic            vend;    // value ends with the last result
	} xerd_group_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} xerd_digit_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
	} xerd_utf8_t;

	// Decimal or hex digit value of one byte
	function automatic xerd_digit_t digit_value(input logic [7:0] b, input logic hex);
		xerd_digit_t r;
		r.ok  = 1'b0;
		r.val = 4'd0;
		if (b >= "0" && b <= "9") begin
			r.ok  = 1'b1;
			r.val = b[3:0];
		end else if (hex && ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))) begin
			r.ok  = 1'b1;
			r.val = 4'(b[2:0] + 3'd1) + 4'd8;
		end
		return r;
	endfunction

	// UTF-8 encoding of a code point below 0x200000
	function automatic xerd_utf8_t utf8_encode(input logic [20:0] c);
		xerd_utf8_t r;
		r.bytes = '0;
		if (c < UTF8_LIM1) begin
			r.bytes[0] = c[7:0];
			r.cnt_m1   = 2'd0;
		end else if (c < UTF8_LIM2) begin
			r.bytes[0] = {3'b110, c[10:6]};
			r.bytes[1] = {2'b10, c[5:0]};
			r.cnt_m1   = 2'd1;
		end else if (c < UTF8_LIM3) begin
			r.bytes[0] = {4'b1110, c[15:12]};
			r.bytes[1] = {2'b10, c[11:6]};
			r.bytes[2] = {2'b10, c[5:0]};
			r.cnt_m1   = 2'd2;
		end else begin
			r.bytes[0] = {5'b11110, c[20:18]};
			r.bytes[1] = {2'b10, c[17:12]};
			r.bytes[2] = {2'b10, c[11:6]};
			r.bytes[3] = {2'b10, c[5:0]};
			r.cnt_m1   = 2'd3;
		end
		return r;
	endfunction

endpackage

@@ rtl/xml_entity_reference_decoder_unit.sv @@
`timescale 1ns / 1ps

// XML attribute-value entity decoder.
// Input channel (in_valid/in_ready): one byte of an attribute value per
// transfer, value_last marking the final byte of a value. Output channel
// (out_valid/out_ready): one result per transfer; a data byte
// (byte_valid), an error (decode_error) or an empty end marker, with
// value_end on the last result of a value.
// Named entities and numeric references become UTF-8 of 1 to 4 bytes;
// after an error, bytes are dropped until the value ends.
// Path: an input byte is registered, then decoded into a result group
// queue. Throughput: one input byte and one result per cycle while the
// queue has room and the receiver is ready; a group of several results
// drains one result per cycle from the queue while the receiver is ready.
// When the receiver stalls, the queue (GROUP_DEPTH groups) fills and then
// in_ready drops; nothing is lost. Reset clears the matcher, the input
// register and the queue; no results are pending afterwards.
`include "assert_macros.svh"

module xml_entity_reference_decoder_unit #(
	parameter int GROUP_DEPTH = xerd_pkg::GROUP_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       value_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       decode_error,
	output logic       value_end
);

	localparam int PtrW = $clog2(GROUP_DEPTH);
	localparam int CntW = $clog2(GROUP_DEPTH + 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(GROUP_DEPTH);
	localparam logic [PtrW-1:0] PtrLast  = PtrW'(GROUP_DEPTH - 1);

	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       value_last_s1;
	logic       step, push, pop, out_xfer, grp_valid;

	xerd_pkg::xerd_group_t grp_new, head;
	xerd_pkg::xerd_group_t grp_q [GROUP_DEPTH];

	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] grp_cnt_q;
	logic [1:0]      idx_q;
	logic            head_last;

	// Input register handshake
	assign step     = valid_s1 && (grp_cnt_q < DepthCnt);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_byte_s1    <= in_byte;
			value_last_s1 <= value_last;
		end
	end

	// Decode stage
	xerd_decoder u_decoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.in_byte    (in_byte_s1),
		.value_last (value_last_s1),
		.grp_valid  (grp_valid),
		.grp        (grp_new)
	);

	// Result group queue
	assign head      = grp_q[rd_ptr_q];
	assign head_last = (idx_q == head.cnt_m1);
	assign push      = step && grp_valid;
	assign out_xfer  = out_valid && out_ready;
	assign pop       = out_xfer && head_last;

	always_ff @(posedge clk) begin
		if (push) begin
			grp_q[wr_ptr_q] <= grp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			grp_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
				idx_q    <= '0;
			end else if (out_xfer) begin
				idx_q <= idx_q + 2'd1;
			end
			if (push && !pop) begin
				grp_cnt_q <= grp_cnt_q + 1'b1;
			end else if (pop && !push) begin
				grp_cnt_q <= grp_cnt_q - 1'b1;
			end
		end
	end

	// Output from the head group, one result per transfer
	assign out_valid    = (grp_cnt_q != '0);
	assign out_byte     = head.data ? head.bytes[idx_q] : 8'h00;
	assign byte_valid   = head.data;
	assign decode_error = head.err;
	assign value_end    = head.vend && head_last;

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, grp_cnt_q > DepthCnt)
	`ASSERT_PROP(a_idx_in_group, clk, arst_n, out_valid |-> (idx_q <= head.cnt_m1))
	`ASSERT_NEVER(a_err_no_data, clk, arst_n, out_valid && decode_error && byte_valid)
	`ASSERT_PROP(a_end_restarts, clk, arst_n, (out_xfer && value_end) |=> (idx_q == 2'd0))
	`ASSERT_PROP(a_full_stalls, clk, arst_n, (valid_s1 && grp_cnt_q == DepthCnt) |-> !in_ready)

endmodule

@@ rtl/xerd_decoder.sv @@
`timescale 1ns / 1ps

// Entity matcher and numeric reference accumulator. One byte per step;
// the result group for that byte is presented combinationally.
module xerd_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         in_byte,
	input  logic               value_last,
	output logic               grp_valid,
	output xerd_pkg::xerd_group_t grp
);

	localparam logic [7:0] NBSP_HI = 8'hC2;
	localparam logic [7:0] NBSP_LO = 8'hA0;

	xerd_pkg::xerd_state_t state_q, state_d, nxt;
	logic [20:0] accum_q, accum_d;
	logic        ovf_q, ovf_d;
	logic        hex_q, hex_d;
	logic        disc_q, disc_d;
	logic        err;
	logic [24:0] acc_wide, prod, sum;

	xerd_pkg::xerd_digit_t dig;
	xerd_pkg::xerd_utf8_t  enc;

	// Next accumulator value: times 10 or 16 plus digit
	assign dig      = xerd_pkg::digit_value(in_byte, hex_q);
	assign enc      = xerd_pkg::utf8_encode(accum_q);
	assign acc_wide = {4'b0, accum_q};
	assign prod     = hex_q ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
	assign sum      = prod + {21'b0, dig.val};

	// Matcher and result group
	always_comb begin
		state_d   = state_q;
		accum_d   = accum_q;
		ovf_d     = ovf_q;
		hex_d     = hex_q;
		disc_d    = disc_q;
		nxt       = xerd_pkg::ST_IDLE;
		err       = 1'b0;
		grp       = '0;
		grp_valid = 1'b0;
		if (disc_q) begin
			// dropping bytes until the value ends
			if (value_last) begin
				disc_d    = 1'b0;
				grp_valid = 1'b1;
				grp.vend  = 1'b1;
			end
		end else begin
			unique case (state_q)
				xerd_pkg::ST_AMP: begin
					if (in_byte == "a") nxt = xerd_pkg::ST_A;
					else if (in_byte == "q") nxt = xerd_pkg::ST_Q;
					else if (in_byte == "g") nxt = xerd_pkg::ST_G;
					else if (in_byte == "l") nxt = xerd_pkg::ST_L;
					else if (in_byte == "n") nxt = xerd_pkg::ST_N;
					else if (in_byte == "#") begin
						nxt     = xerd_pkg::ST_HASH;
						accum_d = '0;
						ovf_d   = 1'b0;
						hex_d   = 1'b0;
					end else err = 1'b1;
				end
				xerd_pkg::ST_A: begin
					if (in_byte == "m") nxt = xerd_pkg::ST_AM;
					else if (in_byte == "p") nxt = xerd_pkg::ST_AP;
					else err = 1'b1;
				end
				xerd_pkg::ST_AM: begin
					if (in_byte == "p") nxt = xerd_pkg::ST_AMP_END; else err = 1'b1;
				end
				xerd_pkg::ST_AP: begin
					if (in_byte == "o") nxt = xerd_pkg::ST_APO; else err = 1'b1;
				end
				xerd_pkg::ST_APO: begin
					if (in_byte == "s") nxt = xerd_pkg::ST_APOS_END; else err = 1'b1;
				end
				xerd_pkg::ST_Q: begin
					if (in_byte == "u") nxt = xerd_pkg::ST_QU; else err = 1'b1;
				end
				xerd_pkg::ST_QU: begin
					if (in_byte == "o") nxt = xerd_pkg::ST_QUO; else err = 1'b1;
				end
				xerd_pkg::ST_QUO: begin
					if (in_byte == "t") nxt = xerd_pkg::ST_QUOT_END; else err = 1'b1;
				end
				xerd_pkg::ST_G: begin
					if (in_byte == "t") nxt = xerd_pkg::ST_GT_END; else err = 1'b1;
				end
				xerd_pkg::ST_L: begin
					if (in_byte == "t") nxt = xerd_pkg::ST_LT_END; else err = 1'b1;
				end
				xerd_pkg::ST_N: begin
					if (in_byte == "b") nxt = xerd_pkg::ST_NB; else err = 1'b1;
				end
				xerd_pkg::ST_NB: begin
					if (in_byte == "s") nxt = xerd_pkg::ST_NBS; else err = 1'b1;
				end
				xerd_pkg::ST_NBS: begin
					if (in_byte == "p") nxt = xerd_pkg::ST_NBSP_END; else err = 1'b1;
				end
				// name complete, expect the closing semicolon
				xerd_pkg::ST_AMP_END, xerd_pkg::ST_APOS_END, xerd_pkg::ST_QUOT_END,
				xerd_pkg::ST_GT_END, xerd_pkg::ST_LT_END, xerd_pkg::ST_NBSP_END: begin
					if (in_byte != ";") begin
						err = 1'b1;
					end else begin
						grp_valid = 1'b1;
						grp.data  = 1'b1;
						unique case (state_q)
							xerd_pkg::ST_AMP_END:  grp.bytes[0] = "&";
							xerd_pkg::ST_APOS_END: grp.bytes[0] = "'";
							xerd_pkg::ST_QUOT_END: grp.bytes[0] = "\"";
							xerd_pkg::ST_GT_END:   grp.bytes[0] = ">";
							xerd_pkg::ST_LT_END:   grp.bytes[0] = "<";
							default: begin
								grp.bytes[0] = NBSP_HI;
								grp.bytes[1] = NBSP_LO;
								grp.cnt_m1   = 2'd1;
							end
						endcase
					end
				end
				// numeric reference
				xerd_pkg::ST_HASH, xerd_pkg::ST_NUM: begin
					if (state_q == xerd_pkg::ST_HASH && in_byte == "x") begin
						hex_d = 1'b1;
						nxt   = xerd_pkg::ST_NUM;
					end else if (dig.ok) begin
						nxt = xerd_pkg::ST_NUM;
						if (!ovf_q) begin
							if (sum >= {4'b0, xerd_pkg::CODE_LIMIT}) ovf_d = 1'b1;
							else accum_d = sum[20:0];
						end
					end else if (in_byte == ";") begin
						if (ovf_q) begin
							err = 1'b1;
						end else begin
							grp_valid  = 1'b1;
							grp.data   = 1'b1;
							grp.bytes  = enc.bytes;
							grp.cnt_m1 = enc.cnt_m1;
						end
					end else begin
						err = 1'b1;
					end
				end
				// idle and unused codes
				default: begin
					if (in_byte == "&") begin
						nxt = xerd_pkg::ST_AMP;
					end else begin
						grp_valid    = 1'b1;
						grp.data     = 1'b1;
						grp.bytes[0] = in_byte;
					end
				end
			endcase

			// error or value ending inside an entity
			if (err) begin
				nxt       = xerd_pkg::ST_IDLE;
				grp       = '0;
				grp.err   = 1'b1;
				grp_valid = 1'b1;
				disc_d    = !value_last;
			end else if (value_last && nxt != xerd_pkg::ST_IDLE) begin
				nxt       = xerd_pkg::ST_IDLE;
				grp       = '0;
				grp.err   = 1'b1;
				grp_valid = 1'b1;
			end
			state_d  = nxt;
			grp.vend = value_last;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xerd_pkg::ST_IDLE;
			accum_q <= '0;
			ovf_q   <= 1'b0;
			hex_q   <= 1'b0;
			disc_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			accum_q <= accum_d;
			ovf_q   <= ovf_d;
			hex_q   <= hex_d;
			disc_q  <= disc_d;
		end
	end

endmodule
